FILE: sv/conv3_pkg.sv
// ----------------------------------------------------------------------------
// conv3_pkg: shared constants, types and helpers
// Geometry limits, sample and product types, register codes and the item
// descriptor that travels from the line-store front end to the MAC stage.
// ----------------------------------------------------------------------------
package conv3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int PART_W    = PROD_W + 2;
    localparam int VALUE_W   = PROD_W + 3;
    localparam int CFG_DIM_W = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 3 * SAMPLE_W;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int W_DIM_W = $clog2(MAX_WIDTH + 1);
    localparam int H_DIM_W = $clog2(MAX_HEIGHT + 1);

    localparam logic [CFG_DIM_W-1:0] RESET_DIM = CFG_DIM_W'(16);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [PART_W-1:0]   part_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef sample_t [2:0]              row_t;
    typedef row_t [2:0]                 window_t;
    typedef logic [2:0][2:0][SAMPLE_W-1:0] kernel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_KERNEL_TOP,
        REG_KERNEL_MIDDLE,
        REG_KERNEL_BOTTOM
    } cfg_reg_t;

    // What one item asks of the MAC stage
    typedef struct packed {
        logic emit_a;    // interior / left result, window columns 0..2
        logic emit_b;    // right-edge result, window columns 1..2
        logic rv0;       // top kernel row inside the frame
        logic rv2;       // bottom kernel row inside the frame
        logic cv0_a;     // left kernel column inside the frame, first result
        logic cv0_b;     // left kernel column inside the frame, edge result
        logic last_row;
    } item_t;

    function automatic logic [W_DIM_W-1:0] eff_width(input logic [CFG_DIM_W-1:0] v);
        logic [W_DIM_W-1:0] res;
        if (v == '0)
            res = W_DIM_W'(1);
        else if (32'(v) > MAX_WIDTH)
            res = W_DIM_W'(MAX_WIDTH);
        else
            res = W_DIM_W'(v);
        return res;
    endfunction

    function automatic logic [H_DIM_W-1:0] eff_height(input logic [CFG_DIM_W-1:0] v);
        logic [H_DIM_W-1:0] res;
        if (v == '0)
            res = H_DIM_W'(1);
        else if (32'(v) > MAX_HEIGHT)
            res = H_DIM_W'(MAX_HEIGHT);
        else
            res = H_DIM_W'(v);
        return res;
    endfunction

endpackage

FILE: sv/conv3x3_zero_padded_stream.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_stream: 3x3 zero-padded convolution of a sample stream
// Samples arrive in raster order; after the last row the source sends one
// row of pad items. Each item yields the result one row up and one column
// left, and the last column also yields the right-edge result.
//
// Input channel: in_valid / in_stall / sample. Output channel: out_valid /
// out_stall / conv_value, row_end, frame_end. Configuration: cfg_valid /
// cfg_ready / cfg_index / cfg_data, always ready; write only while idle.
// A geometry write restarts the frame at row 0, column 0.
// An accepted item passes the line-store stage, the window and issue registers,
// the multiplier stage, the partial-sum stage and the output register; the edge
// result follows the first. Throughput is one item per cycle while the output
// does not stall, except last-column items of rows 1 and up when W >= 2,
// which hold the nine multipliers for both their results.
// The line store is one memory word per column, read at accept and
// written back one stage later; back-to-back reads of the same column take
// the bypassed write data.
// Reset clears counters, window and pipeline; width and height go to 16 and
// the kernel to zero. A stalled receiver fills the output register, the adder
// and multiplier stages, the issue registers and the line-store stage, then stalls input.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded_stream
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [15:0]                sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [34:0]                conv_value,
    output logic                              row_end,
    output logic                              frame_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [conv3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [conv3_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [conv3_pkg::W_DIM_W-1:0] width_reg;
    logic [conv3_pkg::H_DIM_W-1:0] height_reg;
    conv3_pkg::kernel_t            kernel_reg;
    logic                          restart;
    logic                          cfg_wr;

    logic               item_valid;
    logic               item_ready;
    conv3_pkg::item_t   item;
    conv3_pkg::window_t window;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && ((cfg_index == conv3_pkg::REG_FRAME_WIDTH)
                               || (cfg_index == conv3_pkg::REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= conv3_pkg::eff_width(conv3_pkg::RESET_DIM);
            height_reg <= conv3_pkg::eff_height(conv3_pkg::RESET_DIM);
            kernel_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (conv3_pkg::cfg_reg_t'(cfg_index))
                conv3_pkg::REG_FRAME_WIDTH:
                    width_reg <= conv3_pkg::eff_width(cfg_data[conv3_pkg::CFG_DIM_W-1:0]);
                conv3_pkg::REG_FRAME_HEIGHT:
                    height_reg <= conv3_pkg::eff_height(cfg_data[conv3_pkg::CFG_DIM_W-1:0]);
                conv3_pkg::REG_KERNEL_TOP:
                    kernel_reg[0] <= cfg_data;
                conv3_pkg::REG_KERNEL_MIDDLE:
                    kernel_reg[1] <= cfg_data;
                conv3_pkg::REG_KERNEL_BOTTOM:
                    kernel_reg[2] <= cfg_data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    conv3_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .width      (width_reg),
        .height     (height_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .window     (window)
    );

    conv3_mac u_mac
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .kernel     (kernel_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .window     (window),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .conv_value (conv_value),
        .row_end    (row_end),
        .frame_end  (frame_end)
    );

endmodule

FILE: sv/conv3_front.sv
// ----------------------------------------------------------------------------
// conv3_front: position counters, line store and 3x3 window
// Reads the two stored rows at the item's column, writes them back shifted
// by one row and advances the window by one column per item.
// ----------------------------------------------------------------------------
module conv3_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [conv3_pkg::W_DIM_W-1:0] width,
    input  logic [conv3_pkg::H_DIM_W-1:0] height,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  conv3_pkg::sample_t            sample,
    output logic                          item_valid,
    input  logic                          item_ready,
    output conv3_pkg::item_t              item,
    output conv3_pkg::window_t            window
);

    localparam int WORD_W = 2 * conv3_pkg::SAMPLE_W;

    logic [WORD_W-1:0] line_mem [conv3_pkg::MAX_WIDTH];

    logic [conv3_pkg::COL_W-1:0]   col_reg;
    logic [conv3_pkg::H_DIM_W-1:0] row_reg;

    logic                        s1_valid_reg;
    logic [conv3_pkg::COL_W-1:0] s1_col_reg;
    conv3_pkg::sample_t          s1_sample_reg;
    conv3_pkg::item_t            s1_item_reg;
    logic                        s1_fwd_reg;
    logic [WORD_W-1:0]           s1_fwd_data_reg;
    logic [WORD_W-1:0]           rd_data_reg;
    conv3_pkg::window_t          window_reg;

    logic               acc;
    logic               s1_adv;
    logic               col_last;
    logic [WORD_W-1:0]  rd_word;
    conv3_pkg::sample_t older;
    conv3_pkg::sample_t newer;
    logic [WORD_W-1:0]  wr_data;
    conv3_pkg::item_t   item_next;

    assign s1_adv   = s1_valid_reg && item_ready;
    assign in_stall = s1_valid_reg && !item_ready;
    assign acc      = in_valid && !in_stall;
    assign col_last = (conv3_pkg::W_DIM_W'(col_reg) == width - 1'b1);

    // Previous item wrote this entry in the cycle it was read: take its data
    assign rd_word = s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg;
    assign older   = rd_word[WORD_W-1:conv3_pkg::SAMPLE_W];
    assign newer   = rd_word[conv3_pkg::SAMPLE_W-1:0];
    assign wr_data = {newer, s1_sample_reg};

    always_comb
    begin
        item_next.emit_a   = (row_reg != '0) && (col_reg != '0);
        item_next.emit_b   = (row_reg != '0) && col_last;
        item_next.rv0      = (row_reg >= conv3_pkg::H_DIM_W'(2));
        item_next.rv2      = (row_reg < height);
        item_next.cv0_a    = (col_reg >= conv3_pkg::COL_W'(2));
        item_next.cv0_b    = (width != conv3_pkg::W_DIM_W'(1));
        item_next.last_row = (row_reg == height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == height) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else if (acc)
        begin
            s1_valid_reg <= 1'b1;
            s1_fwd_reg   <= s1_adv && (s1_col_reg == col_reg);
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_col_reg      <= col_reg;
            s1_sample_reg   <= (row_reg < height) ? sample : '0;
            s1_item_reg     <= item_next;
            s1_fwd_data_reg <= wr_data;
        end
    end

    // Line store: one read at accept, one write-back as the item leaves
    always_ff @(posedge clk)
    begin
        if (acc)
            rd_data_reg <= line_mem[col_reg];
        if (s1_adv)
            line_mem[s1_col_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (s1_adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                window_reg[k][0] <= window_reg[k][1];
                window_reg[k][1] <= window_reg[k][2];
            end
            window_reg[0][2] <= older;
            window_reg[1][2] <= newer;
            window_reg[2][2] <= s1_sample_reg;
        end
    end

    assign item_valid = s1_valid_reg;
    assign item       = s1_item_reg;
    assign window     = window_reg;

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        conv3_pkg::W_DIM_W'(col_reg) < width)
        else $error("column counter beyond frame width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= height)
        else $error("row counter beyond pad row");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> s1_valid_reg)
        else $error("accepted item lost before line store access");

endmodule

FILE: sv/conv3_mac.sv
// ----------------------------------------------------------------------------
// conv3_mac: result issue, nine multipliers and adder tree
// Issues up to two results per item, each from nine masked products,
// summed in two registered adder levels into the output register.
// ----------------------------------------------------------------------------
module conv3_mac
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  conv3_pkg::kernel_t    kernel,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  conv3_pkg::item_t      item,
    input  conv3_pkg::window_t    window,
    output logic                  out_valid,
    input  logic                  out_stall,
    output conv3_pkg::value_t     conv_value,
    output logic                  row_end,
    output logic                  frame_end
);

    logic             pa_reg;
    logic             pb_reg;
    conv3_pkg::item_t it_reg;

    logic                              s3_valid_reg;
    conv3_pkg::prod_t [2:0][2:0]       prod_reg;
    logic                              s3_re_reg;
    logic                              s3_fe_reg;
    logic                              s4_valid_reg;
    conv3_pkg::part_t [2:0]            part_reg;
    logic                              s4_re_reg;
    logic                              s4_fe_reg;
    logic                              out_valid_reg;
    conv3_pkg::value_t                 conv_value_reg;
    logic                              row_end_reg;
    logic                              frame_end_reg;

    logic                              issue;
    logic                              issue_b;
    logic                              out_ready;
    logic                              s4_ready;
    logic                              s3_ready;
    conv3_pkg::prod_t [2:0][2:0]       prod_next;
    conv3_pkg::part_t [2:0]            part_next;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;

    assign issue_b    = !pa_reg && pb_reg;
    assign issue      = (pa_reg || pb_reg) && s3_ready;
    assign item_ready = (!pa_reg && !pb_reg) || (s3_ready && (pa_reg ^ pb_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_reg <= 1'b0;
            pb_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                if (pa_reg)
                    pa_reg <= 1'b0;
                else
                    pb_reg <= 1'b0;
            end
            if (item_valid && item_ready)
            begin
                pa_reg <= item.emit_a;
                pb_reg <= item.emit_b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            it_reg <= item;
    end

    // Edge result uses window columns 1..2 under kernel columns 0..1
    always_comb
    begin
        conv3_pkg::row_t    row_sel;
        logic               row_ok;
        logic               col_ok;
        conv3_pkg::sample_t op;
        for (int kr = 0; kr < 3; kr++)
        begin
            row_sel = issue_b ? conv3_pkg::row_t'(window[kr] >> conv3_pkg::SAMPLE_W)
                              : window[kr];
            row_ok  = (kr == 0) ? it_reg.rv0 : ((kr == 2) ? it_reg.rv2 : 1'b1);
            for (int kc = 0; kc < 3; kc++)
            begin
                if (issue_b)
                    col_ok = (kc == 0) ? it_reg.cv0_b : (kc == 1);
                else
                    col_ok = (kc == 0) ? it_reg.cv0_a : 1'b1;
                op = (row_ok && col_ok) ? row_sel[kc] : '0;
                prod_next[kr][kc] = conv3_pkg::PROD_W'(op * $signed(kernel[kr][kc]));
            end
        end
    end

    always_comb
    begin
        for (int kr = 0; kr < 3; kr++)
        begin
            part_next[kr] = conv3_pkg::PART_W'(prod_reg[kr][0])
                          + conv3_pkg::PART_W'(prod_reg[kr][1])
                          + conv3_pkg::PART_W'(prod_reg[kr][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
                s3_valid_reg <= issue;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
            if (out_ready)
                out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            prod_reg  <= prod_next;
            s3_re_reg <= issue_b;
            s3_fe_reg <= issue_b && it_reg.last_row;
        end
        if (s4_ready)
        begin
            part_reg  <= part_next;
            s4_re_reg <= s3_re_reg;
            s4_fe_reg <= s3_fe_reg;
        end
        if (out_ready)
        begin
            conv_value_reg <= conv3_pkg::VALUE_W'(part_reg[0])
                            + conv3_pkg::VALUE_W'(part_reg[1])
                            + conv3_pkg::VALUE_W'(part_reg[2]);
            row_end_reg    <= s4_re_reg;
            frame_end_reg  <= s4_fe_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign conv_value = conv_value_reg;
    assign row_end    = row_end_reg;
    assign frame_end  = frame_end_reg;

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> row_end_reg)
        else $error("frame end without row end");

    a_two_results_pending: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.emit_a && item.emit_b |=> pa_reg && pb_reg)
        else $error("edge item did not queue both results");

endmodule

FILE: tb/sv/tb_conv3x3_zero_padded_stream.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_conv3x3_zero_padded_stream: self-checking bench for the 3x3 convolution
// Streams raster frames with their pad row into the block and predicts every
// result with a bit-exact model of the line stores, the window and the edge
// masking. Directed frames hit the reset geometry, a single column and the
// largest sums. Random frames then vary geometry, kernel, aborted frames and
// kernel rewrites in mid-frame, under three idling patterns on both sides.
// ----------------------------------------------------------------------------
module tb_conv3x3_zero_padded_stream;

    localparam int NUM_REGS        = int'(conv3_pkg::REG_KERNEL_BOTTOM) + 1;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 300;

    typedef struct {
        conv3_pkg::value_t value;
        logic              row_end;
        logic              frame_end;
    } conv_result_t;

    class conv_scoreboard;
        logic [conv3_pkg::CFG_DIM_W-1:0]  width_reg;
        logic [conv3_pkg::CFG_DIM_W-1:0]  height_reg;
        logic [conv3_pkg::CFG_DATA_W-1:0] kernel_rows [3];
        conv3_pkg::sample_t               older_row [conv3_pkg::MAX_WIDTH];
        conv3_pkg::sample_t               newer_row [conv3_pkg::MAX_WIDTH];
        conv3_pkg::sample_t               win [3][3];
        int unsigned                      col;
        int unsigned                      row;
        conv_result_t                     expected_q [$];
        int unsigned                      failures;

        function new();
            width_reg  = conv3_pkg::RESET_DIM;
            height_reg = conv3_pkg::RESET_DIM;
            foreach (kernel_rows[i])
                kernel_rows[i] = '0;
            foreach (older_row[i])
            begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            foreach (win[i, j])
                win[i][j] = '0;
            col      = 0;
            row      = 0;
            failures = 0;
        endfunction

        function int unsigned clamp_dim(logic [conv3_pkg::CFG_DIM_W-1:0] v,
                                        int unsigned maxv);
            if (v == '0)
                return 1;
            return (v > maxv) ? maxv : int'(v);
        endfunction

        // frame rows plus the pad row
        function int unsigned frame_items(logic [conv3_pkg::CFG_DIM_W-1:0] w_cfg,
                                          logic [conv3_pkg::CFG_DIM_W-1:0] h_cfg);
            return clamp_dim(w_cfg, conv3_pkg::MAX_WIDTH)
                 * (clamp_dim(h_cfg, conv3_pkg::MAX_HEIGHT) + 1);
        endfunction

        function void write_reg(logic [conv3_pkg::CFG_IDX_W-1:0] idx,
                                logic [conv3_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                conv3_pkg::REG_FRAME_WIDTH:
                begin
                    width_reg = data[conv3_pkg::CFG_DIM_W-1:0];
                    col = 0;
                    row = 0;
                end
                conv3_pkg::REG_FRAME_HEIGHT:
                begin
                    height_reg = data[conv3_pkg::CFG_DIM_W-1:0];
                    col = 0;
                    row = 0;
                end
                conv3_pkg::REG_KERNEL_TOP:    kernel_rows[0] = data;
                conv3_pkg::REG_KERNEL_MIDDLE: kernel_rows[1] = data;
                conv3_pkg::REG_KERNEL_BOTTOM: kernel_rows[2] = data;
                default: ;
            endcase
        endfunction

        // kernel column kc meets window column kc + shift; rv / cv mask rows / columns
        function longint window_sum(int unsigned shift, bit [2:0] rv, bit [2:0] cv);
            longint             acc;
            int unsigned        wc;
            conv3_pkg::sample_t coef;
            acc = 0;
            for (int kr = 0; kr < 3; kr++)
                for (int kc = 0; kc < 3; kc++)
                begin
                    wc = kc + shift;
                    if (rv[kr] && cv[kc] && wc <= 2)
                    begin
                        coef = conv3_pkg::sample_t'(
                            kernel_rows[kr][conv3_pkg::SAMPLE_W*kc +: conv3_pkg::SAMPLE_W]);
                        acc += longint'(win[kr][wc]) * longint'(coef);
                    end
                end
            return acc;
        endfunction

        function void push_expected(longint v, logic re, logic fe);
            conv_result_t e;
            e.value     = conv3_pkg::value_t'(v);
            e.row_end   = re;
            e.frame_end = fe;
            expected_q.push_back(e);
        endfunction

        function void note_input(conv3_pkg::sample_t s);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            bit [2:0]    rv;
            w = clamp_dim(width_reg, conv3_pkg::MAX_WIDTH);
            h = clamp_dim(height_reg, conv3_pkg::MAX_HEIGHT);
            c = col;
            r = row;
            if (c >= w)
                c = 0;
            if (r > h)
                r = 0;
            for (int k = 0; k < 3; k++)
            begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = older_row[c];
            win[1][2] = newer_row[c];
            win[2][2] = (r < h) ? s : conv3_pkg::sample_t'(0);
            older_row[c] = newer_row[c];
            newer_row[c] = win[2][2];
            if (r >= 1)
            begin
                rv = {r < h, 1'b1, r >= 2};
                if (c >= 1)
                    push_expected(window_sum(0, rv, {1'b1, 1'b1, c >= 2}), 1'b0, 1'b0);
                if (c == w - 1)
                    push_expected(window_sum(1, rv, {1'b0, 1'b1, w >= 2}), 1'b1, r == h);
            end
            c++;
            if (c >= w)
            begin
                c = 0;
                r = (r >= h) ? 0 : r + 1;
            end
            col = c;
            row = r;
        endfunction

        function void check_result(conv3_pkg::value_t v, logic re, logic fe);
            conv_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: conv_value %0d row_end %0b frame_end %0b",
                       v, re, fe);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (v !== e.value)
            begin
                $error("conv_value: expected %0d, got %0d", e.value, v);
                failures++;
            end
            if (re !== e.row_end)
            begin
                $error("row_end: expected %0b, got %0b", e.row_end, re);
                failures++;
            end
            if (fe !== e.frame_end)
            begin
                $error("frame_end: expected %0b, got %0b", e.frame_end, fe);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    conv3_pkg::sample_t               sample    = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    conv3_pkg::value_t                conv_value;
    logic                             row_end;
    logic                             frame_end;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [conv3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [conv3_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    quiet_cycles   = 0;
    conv_scoreboard sb;

    always #10 clk = ~clk;

    conv3x3_zero_padded_stream dut (.*);

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // results first, so an input in the same cycle cannot satisfy them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(conv_value, row_end, frame_end);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_input(sample);
            if ((out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
                (in_valid && !in_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic conv3_pkg::sample_t rand_sample();
        case ($urandom_range(7))
            0:       return conv3_pkg::sample_t'(-32768);
            1:       return conv3_pkg::sample_t'(32767);
            2:       return conv3_pkg::sample_t'(0);
            3:       return conv3_pkg::sample_t'(-1);
            default: return conv3_pkg::sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [conv3_pkg::CFG_DATA_W-1:0] rand_kernel_row();
        logic [conv3_pkg::CFG_DATA_W-1:0] k;
        for (int i = 0; i < 3; i++)
            k[conv3_pkg::SAMPLE_W*i +: conv3_pkg::SAMPLE_W] = rand_sample();
        return k;
    endfunction

    // mostly small frames; an occasional zero exercises the clamp to one
    function automatic logic [conv3_pkg::CFG_DIM_W-1:0] pick_dim();
        if ($urandom_range(15) == 0)
            return '0;
        return conv3_pkg::CFG_DIM_W'($urandom_range(7, 1));
    endfunction

    task automatic send_sample(input conv3_pkg::sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // leaves cfg_valid high so back-to-back writes need no gap
    task automatic cfg_write(input logic [conv3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [conv3_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // wait for every expected result, then let items with no result leave the pipe
    task automatic drain_pipeline();
        do
        begin
            while (sb.pending() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (sb.pending() != 0);
    endtask

    task automatic run_frame(input logic [conv3_pkg::CFG_DIM_W-1:0] w_cfg,
                             input logic [conv3_pkg::CFG_DIM_W-1:0] h_cfg,
                             input bit directed, input conv3_pkg::sample_t fill);
        logic [conv3_pkg::CFG_DATA_W-1:0] d;
        int unsigned                      n;
        int unsigned                      cut;
        int unsigned                      mode;
        drain_pipeline();
        // junk above the dimension bits must be dropped
        d = {$urandom, $urandom};
        d[conv3_pkg::CFG_DIM_W-1:0] = w_cfg;
        cfg_write(conv3_pkg::REG_FRAME_WIDTH, d);
        d = {$urandom, $urandom};
        d[conv3_pkg::CFG_DIM_W-1:0] = h_cfg;
        cfg_write(conv3_pkg::REG_FRAME_HEIGHT, d);
        if (!directed)
        begin
            for (int i = 0; i < 3; i++)
                if ($urandom_range(1))
                    cfg_write(conv3_pkg::CFG_IDX_W'(int'(conv3_pkg::REG_KERNEL_TOP) + i),
                              rand_kernel_row());
            if ($urandom_range(9) == 0)
                cfg_write(conv3_pkg::CFG_IDX_W'(NUM_REGS + $urandom_range(2)),
                          {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;
        n    = sb.frame_items(w_cfg, h_cfg);
        mode = directed ? 9 : $urandom_range(9);
        cut  = (n > 1) ? $urandom_range(n - 1, 1) : n;
        for (int i = 0; i < n; i++)
        begin
            // mode 0: abandon the frame; mode 1: swap a kernel row mid-frame
            if (mode < 2 && i == cut)
            begin
                in_valid <= 1'b0;
                drain_pipeline();
                if (mode == 0)
                    break;
                cfg_write(conv3_pkg::CFG_IDX_W'(int'(conv3_pkg::REG_KERNEL_TOP)
                                                + $urandom_range(2)),
                          rand_kernel_row());
                cfg_valid <= 1'b0;
            end
            send_sample(directed ? fill : rand_sample());
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned                     sent;
        logic [conv3_pkg::CFG_DIM_W-1:0] w;
        logic [conv3_pkg::CFG_DIM_W-1:0] h;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct  = 37;
        recv_stall_pct = 49;

        // reset geometry and zero kernel; the width write below cuts this frame short
        for (int i = 0; i < 17; i++)
            send_sample(rand_sample());
        in_valid <= 1'b0;
        drain_pipeline();
        cfg_write(conv3_pkg::REG_KERNEL_TOP,    {3{conv3_pkg::sample_t'(-32768)}});
        cfg_write(conv3_pkg::REG_KERNEL_MIDDLE, {3{conv3_pkg::sample_t'(-32768)}});
        cfg_write(conv3_pkg::REG_KERNEL_BOTTOM, {3{conv3_pkg::sample_t'(-32768)}});
        cfg_valid <= 1'b0;
        // zero width clamps to a single column
        run_frame('0, conv3_pkg::CFG_DIM_W'(1), 1'b1, conv3_pkg::sample_t'(-32768));
        // full window of the most negative samples and coefficients: the largest sum
        run_frame(conv3_pkg::CFG_DIM_W'(3), conv3_pkg::CFG_DIM_W'(3), 1'b1,
                  conv3_pkg::sample_t'(-32768));

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 49;
                end
                1:
                begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 37;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                w = pick_dim();
                h = pick_dim();
                run_frame(w, h, 1'b0, '0);
                sent += sb.frame_items(w, h);
            end
        end

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
sv/conv3_pkg.sv
sv/conv3_front.sv
sv/conv3_mac.sv
sv/conv3x3_zero_padded_stream.sv
tb/sv/tb_conv3x3_zero_padded_stream.sv
